// ----- rtl/core/first_fit_fragment_allocator_core_defines.svh -----
// assertion macros shared by the allocator core modules
`ifndef FIRST_FIT_FRAGMENT_ALLOCATOR_CORE_DEFINES_SVH
`define FIRST_FIT_FRAGMENT_ALLOCATOR_CORE_DEFINES_SVH

`ifndef ASSERT_OFF

// property checked at every edge outside reset
`define FFA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("ffa assertion failed");

// same-cycle implication checked outside reset
`define FFA_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ffa implication failed");

`else

`define FFA_ASSERT(lbl, prop)
`define FFA_ASSERT_IMPL(lbl, ante, cons)

`endif

`endif

// ----- rtl/core/ffa_pkg.sv -----
// types and constants of the first-fit fragment allocator
`timescale 1ns / 1ps
`default_nettype none

package ffa_pkg;

  localparam int unsigned AddrW   = 32;
  localparam int unsigned SizeInW = 16;
  localparam int unsigned SizeW   = 17;

  // configuration register indexes
  localparam logic CfgBaseAddr  = 1'b0;
  localparam logic CfgRegionEnd = 1'b1;

  typedef enum logic [1:0] {
    REQ_ALLOC   = 2'd0,
    REQ_REALLOC = 2'd1,
    REQ_FREE    = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NO_SPACE  = 2'd1,
    STAT_FULL      = 2'd2,
    STAT_NOT_FOUND = 2'd3
  } status_e;

  // what the entry stage does with each table entry
  typedef enum logic [1:0] {
    MD_NONE   = 2'd0,
    MD_LOOKUP = 2'd1,
    MD_SEARCH = 2'd2,
    MD_FREE   = 2'd3
  } mode_e;

  // source of a new candidate address
  typedef enum logic [1:0] {
    LD_NONE    = 2'd0,
    LD_ADDR    = 2'd1,
    LD_HIT_END = 2'd2
  } load_e;

  typedef enum logic [2:0] {
    KIND_GRANT     = 3'd0,
    KIND_FREE      = 3'd1,
    KIND_NO_SPACE  = 3'd2,
    KIND_FULL      = 3'd3,
    KIND_NOT_FOUND = 3'd4
  } kind_e;

  typedef struct packed {
    logic  capture;
    logic  scan_start;
    mode_e mode;
    load_e load;
    logic  mem_write;
    logic  fin;
    kind_e kind;
  } cmd_t;

  typedef struct packed {
    req_e req_type;
    logic scan_busy;
    logic pass_done;
    logic hit_found;
    logic shrink;
    logic jumped;
    logic fit;
    logic slot_found;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

// ----- rtl/core/ffa_ctrl.sv -----
// request sequencer of the fragment allocator
`timescale 1ns / 1ps
`default_nettype none

`include "first_fit_fragment_allocator_core_defines.svh"

module ffa_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic [1:0]     req_type_i,
  output logic           in_ready_o,
  input  ffa_pkg::stat_t stat_i,
  output ffa_pkg::cmd_t  cmd_o
);
  import ffa_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_LOOKUP = 8'b0000_0010,
    ST_RDEC   = 8'b0000_0100,
    ST_SEARCH = 8'b0000_1000,
    ST_CHECK  = 8'b0001_0000,
    ST_FREE   = 8'b0010_0000,
    ST_WRITE  = 8'b0100_0000,
    ST_DONE   = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  kind_e  kind_q, kind_d;

  always_comb begin
    state_d    = state_q;
    kind_d     = kind_q;
    cmd_o      = '0;
    cmd_o.kind = kind_q;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          case (req_e'(req_type_i))
            REQ_ALLOC: begin
              cmd_o.scan_start = 1'b1;
              state_d          = ST_SEARCH;
            end
            REQ_REALLOC: begin
              cmd_o.scan_start = 1'b1;
              state_d          = ST_LOOKUP;
            end
            REQ_FREE: begin
              cmd_o.scan_start = 1'b1;
              state_d          = ST_FREE;
            end
            default: begin
              kind_d  = KIND_NOT_FOUND;
              state_d = ST_DONE;
            end
          endcase
        end
      end
      ST_LOOKUP: begin
        cmd_o.mode = MD_LOOKUP;
        if (stat_i.pass_done) begin
          state_d = ST_RDEC;
        end
      end
      ST_RDEC: begin
        if (!stat_i.hit_found) begin
          kind_d  = KIND_NOT_FOUND;
          state_d = ST_DONE;
        end else if (stat_i.shrink) begin
          // keeps its place, only the size changes
          cmd_o.load = LD_ADDR;
          kind_d     = KIND_GRANT;
          state_d    = ST_WRITE;
        end else begin
          cmd_o.load       = LD_HIT_END;
          cmd_o.scan_start = 1'b1;
          state_d          = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        cmd_o.mode = MD_SEARCH;
        if (stat_i.pass_done) begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (stat_i.jumped && stat_i.fit) begin
          cmd_o.scan_start = 1'b1;
          state_d          = ST_SEARCH;
        end else if (stat_i.req_type == REQ_ALLOC && !stat_i.slot_found) begin
          kind_d  = KIND_FULL;
          state_d = ST_DONE;
        end else if (!stat_i.fit) begin
          kind_d  = KIND_NO_SPACE;
          state_d = ST_DONE;
        end else begin
          kind_d  = KIND_GRANT;
          state_d = ST_WRITE;
        end
      end
      ST_FREE: begin
        cmd_o.mode = MD_FREE;
        if (stat_i.pass_done) begin
          kind_d  = KIND_FREE;
          state_d = ST_DONE;
        end
      end
      ST_WRITE: begin
        cmd_o.mem_write = 1'b1;
        state_d         = ST_DONE;
      end
      ST_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.fin = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      kind_q  <= KIND_GRANT;
    end else begin
      state_q <= state_d;
      kind_q  <= kind_d;
    end
  end

  `FFA_ASSERT_IMPL(a_fin_slot_free, cmd_o.fin, stat_i.out_free)
  `FFA_ASSERT_IMPL(a_write_not_scanning, cmd_o.mem_write, !stat_i.scan_busy)
  `FFA_ASSERT_IMPL(a_start_not_scanning, cmd_o.scan_start, !stat_i.scan_busy)

endmodule

`default_nettype wire

// ----- rtl/core/ffa_datapath.sv -----
// fragment table, scan pipeline, candidate address and result register
`timescale 1ns / 1ps
`default_nettype none

`include "first_fit_fragment_allocator_core_defines.svh"

module ffa_datapath #(
  parameter int unsigned TABLE_ENTRIES = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [ffa_pkg::AddrW-1:0]     cfg_data_i,
  input  logic [1:0]                    req_type_i,
  input  logic [ffa_pkg::AddrW-1:0]     address_i,
  input  logic [ffa_pkg::SizeInW-1:0]   size_bytes_i,
  input  logic                          out_ready_i,
  input  ffa_pkg::cmd_t                 cmd_i,
  output ffa_pkg::stat_t                stat_o,
  output logic                          out_valid_o,
  output logic [ffa_pkg::AddrW-1:0]     result_address_o,
  output logic [1:0]                    status_o,
  output logic [ffa_pkg::SizeW-1:0]     granted_size_o,
  output logic                          same_place_o
);
  import ffa_pkg::*;

  localparam int unsigned IdxW = $clog2(TABLE_ENTRIES);

  // fragment table
  logic [AddrW-1:0] mem_start [TABLE_ENTRIES];
  logic [SizeW-1:0] mem_size  [TABLE_ENTRIES];
  logic [AddrW-1:0] mem_end   [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] valid_q;

  logic [AddrW-1:0] base_q, region_q;

  // captured request
  req_e             req_q;
  logic [AddrW-1:0] addr_q;
  logic [SizeW-1:0] size_q;
  logic [SizeW-1:0] size_rnd;

  // candidate span [a, an)
  logic [AddrW:0] a_q, an_q, a_d, an_d;
  logic           a_en;

  // scan pipeline
  logic            scan_act_q;
  logic [IdxW-1:0] rd_idx_q;
  logic            p_vld_q, p_last_q;
  logic [IdxW-1:0] p_idx_q;
  logic            rd_vld_q;
  logic [AddrW-1:0] rd_start_q, rd_end_q;
  logic [SizeW-1:0] rd_size_q;

  // per-request flags
  logic            jumped_q, slot_found_q, hit_found_q, any_q;
  logic [IdxW-1:0] slot_q, hit_idx_q;
  logic [SizeW-1:0] hit_size_q;
  logic [AddrW-1:0] hit_end_q;

  logic            overlap, addr_match;
  logic            ev_search, ev_lookup, ev_free;
  logic [IdxW-1:0] wr_idx;

  // result register
  logic             out_valid_q;
  logic [AddrW-1:0] res_addr_q;
  status_e          res_status_q;
  logic [SizeW-1:0] res_size_q;
  logic             res_same_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q   <= '0;
      region_q <= '1;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CfgBaseAddr) begin
        base_q <= cfg_data_i;
      end
      if (cfg_idx_i == CfgRegionEnd) begin
        region_q <= cfg_data_i;
      end
    end
  end

  // round up to a whole word
  always_comb begin
    size_rnd = {1'b0, size_bytes_i} + SizeW'(3);
    size_rnd = {size_rnd[SizeW-1:2], 2'b00};
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q  <= req_e'(req_type_i);
      addr_q <= address_i;
      size_q <= size_rnd;
    end
  end

  assign addr_match = rd_vld_q && (rd_start_q == addr_q);
  // ends of recorded fragments are always word aligned, so the end is the next candidate
  assign overlap    = rd_vld_q && ({1'b0, rd_start_q} < an_q) && ({1'b0, rd_end_q} > a_q);
  assign ev_search  = p_vld_q && (cmd_i.mode == MD_SEARCH);
  assign ev_lookup  = p_vld_q && (cmd_i.mode == MD_LOOKUP);
  assign ev_free    = p_vld_q && (cmd_i.mode == MD_FREE);

  // one adder serves every way the candidate moves
  always_comb begin
    a_en = 1'b1;
    a_d  = a_q;
    if (cmd_i.capture) begin
      a_d = {1'b0, base_q[AddrW-1:2], 2'b00};
    end else if (cmd_i.load == LD_ADDR) begin
      a_d = {1'b0, addr_q};
    end else if (cmd_i.load == LD_HIT_END) begin
      a_d = {1'b0, hit_end_q};
    end else if (ev_search && overlap) begin
      a_d = {1'b0, rd_end_q};
    end else begin
      a_en = 1'b0;
    end
    an_d = a_d + (AddrW+1)'(cmd_i.capture ? size_rnd : size_q);
  end

  always_ff @(posedge clk_i) begin
    if (a_en) begin
      a_q  <= a_d;
      an_q <= an_d;
    end
  end

  assign wr_idx = (req_q == REQ_ALLOC) ? slot_q : hit_idx_q;

  // table memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_write) begin
      mem_start[wr_idx] <= a_q[AddrW-1:0];
      mem_size[wr_idx]  <= size_q;
      mem_end[wr_idx]   <= an_q[AddrW-1:0];
    end
    rd_start_q <= mem_start[rd_idx_q];
    rd_size_q  <= mem_size[rd_idx_q];
    rd_end_q   <= mem_end[rd_idx_q];
    p_idx_q    <= rd_idx_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_act_q <= 1'b0;
      rd_idx_q   <= '0;
      p_vld_q    <= 1'b0;
      p_last_q   <= 1'b0;
      rd_vld_q   <= 1'b0;
    end else begin
      rd_vld_q <= valid_q[rd_idx_q];
      p_vld_q  <= scan_act_q;
      p_last_q <= (rd_idx_q == IdxW'(TABLE_ENTRIES - 1));
      if (cmd_i.scan_start) begin
        scan_act_q <= 1'b1;
        rd_idx_q   <= '0;
      end else if (scan_act_q) begin
        if (rd_idx_q == IdxW'(TABLE_ENTRIES - 1)) begin
          scan_act_q <= 1'b0;
        end
        rd_idx_q <= rd_idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q      <= '0;
      jumped_q     <= 1'b0;
      slot_found_q <= 1'b0;
      hit_found_q  <= 1'b0;
      any_q        <= 1'b0;
      slot_q       <= '0;
      hit_idx_q    <= '0;
      hit_size_q   <= '0;
      hit_end_q    <= '0;
    end else begin
      if (cmd_i.capture) begin
        slot_found_q <= 1'b0;
        hit_found_q  <= 1'b0;
        any_q        <= 1'b0;
      end
      if (cmd_i.scan_start) begin
        jumped_q <= 1'b0;
      end else if (ev_search && overlap) begin
        jumped_q <= 1'b1;
      end
      if (ev_search && !rd_vld_q && !slot_found_q) begin
        slot_found_q <= 1'b1;
        slot_q       <= p_idx_q;
      end
      if (ev_lookup && addr_match && !hit_found_q) begin
        hit_found_q <= 1'b1;
        hit_idx_q   <= p_idx_q;
        hit_size_q  <= rd_size_q;
        hit_end_q   <= rd_end_q;
      end
      if (ev_free && addr_match) begin
        valid_q[p_idx_q] <= 1'b0;
        any_q            <= 1'b1;
      end
      if (cmd_i.mem_write && req_q == REQ_ALLOC) begin
        valid_q[slot_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.fin) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fin) begin
      res_addr_q   <= '0;
      res_size_q   <= '0;
      res_same_q   <= 1'b0;
      res_status_q <= STAT_OK;
      case (cmd_i.kind)
        KIND_GRANT: begin
          res_addr_q <= a_q[AddrW-1:0];
          res_size_q <= size_q;
          res_same_q <= (req_q == REQ_REALLOC) && (a_q == {1'b0, addr_q});
        end
        KIND_FREE: begin
          if (any_q) begin
            res_addr_q <= addr_q;
          end else begin
            res_status_q <= STAT_NOT_FOUND;
          end
        end
        KIND_NO_SPACE: res_status_q <= STAT_NO_SPACE;
        KIND_FULL:     res_status_q <= STAT_FULL;
        default:       res_status_q <= STAT_NOT_FOUND;
      endcase
    end
  end

  always_comb begin
    stat_o            = '0;
    stat_o.req_type   = req_q;
    stat_o.scan_busy  = scan_act_q || p_vld_q;
    stat_o.pass_done  = p_vld_q && p_last_q;
    stat_o.hit_found  = hit_found_q;
    stat_o.shrink     = hit_size_q >= size_q;
    stat_o.jumped     = jumped_q;
    stat_o.fit        = an_q <= {1'b0, region_q};
    stat_o.slot_found = slot_found_q;
    stat_o.out_free   = !out_valid_q || out_ready_i;
  end

  assign out_valid_o      = out_valid_q;
  assign result_address_o = res_addr_q;
  assign status_o         = res_status_q;
  assign granted_size_o   = res_size_q;
  assign same_place_o     = res_same_q;

  `FFA_ASSERT_IMPL(a_write_span, cmd_i.mem_write, an_q == (a_q + (AddrW+1)'(size_q)))
  `FFA_ASSERT_IMPL(a_alloc_has_slot, cmd_i.mem_write && req_q == REQ_ALLOC, slot_found_q)
  `FFA_ASSERT(a_search_monotonic, ev_search |=> (a_q >= $past(a_q)))

endmodule

`default_nettype wire

// ----- rtl/core/first_fit_fragment_allocator_core.sv -----
// top level of the first-fit fragment allocator
// usage:
//   request channel in_valid_i/in_ready_o carries req_type_i, address_i and
//   size_bytes_i; one transfer is one alloc, realloc or free request
//   result channel out_valid_o/out_ready_i carries one result per request
//   base address and region end are written through cfg_we_i/cfg_idx_i/cfg_data_i
//   while no request is in flight
// timing:
//   a table pass reads one entry per cycle from the single table read port;
//   alloc needs one pass plus one more for every restart after the candidate
//   jumps past a fragment (at most TABLE_ENTRIES + 1 passes); realloc adds one
//   lookup pass, free is a single pass
//   requests are served one at a time in order
// reset: table empty, base address 0, region end all ones
// stall: a finished result waits in the output register; the next request is
//   taken meanwhile and holds in its final step until the result is moved out
`timescale 1ns / 1ps
`default_nettype none

module first_fit_fragment_allocator_core #(
  parameter int unsigned TABLE_ENTRIES = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration writes
  input  logic                        cfg_we_i,
  input  logic                        cfg_idx_i,
  input  logic [ffa_pkg::AddrW-1:0]   cfg_data_i,
  // request channel
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [1:0]                  req_type_i,
  input  logic [ffa_pkg::AddrW-1:0]   address_i,
  input  logic [ffa_pkg::SizeInW-1:0] size_bytes_i,
  // result channel
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [ffa_pkg::AddrW-1:0]   result_address_o,
  output logic [1:0]                  status_o,
  output logic [ffa_pkg::SizeW-1:0]   granted_size_o,
  output logic                        same_place_o
);
  import ffa_pkg::*;

  // command and status between the sequencer and the datapath
  cmd_t  cmd;
  stat_t stat;

  // sequencer: accepts a transfer, steps lookup / search / free passes,
  // decides the outcome and posts the result
  ffa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .req_type_i (req_type_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // datapath: fragment table memory, valid bits, candidate span,
  // scan pipeline and result register
  ffa_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .req_type_i       (req_type_i),
    .address_i        (address_i),
    .size_bytes_i     (size_bytes_i),
    .out_ready_i      (out_ready_i),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .out_valid_o      (out_valid_o),
    .result_address_o (result_address_o),
    .status_o         (status_o),
    .granted_size_o   (granted_size_o),
    .same_place_o     (same_place_o)
  );

endmodule

`default_nettype wire

// ----- verif/tb.sv -----
// self-checking testbench of the first-fit fragment allocator core
`timescale 1ns / 1ps

module tb;
  import ffa_pkg::*;

  // table depth of the instance and of the local table copy
  localparam int unsigned TableEntries = 16;
  // request code that the block must reject
  localparam logic [1:0] ReqUnknown = 2'd3;
  // longest idle stretch either side draws per transfer
  localparam int unsigned MaxGap = 11;
  // one table pass plus margin, waited out once the last result is back
  localparam int unsigned SettleCycles = TableEntries + 5;
  // hard stop, far beyond the slowest legal run
  localparam longint unsigned RunLimitNs = 64'd60_000_000;
  // receiver hold-off during the backpressure test
  localparam int unsigned LongHold = 300;

  // one result as the block must present it
  typedef struct packed {
    logic [AddrW-1:0] address;
    status_e          status;
    logic [SizeW-1:0] size;
    logic             same_place;
  } alloc_result_t;

  // ports, all known from time zero
  logic                 clk_i;
  logic                 rst_ni       = 1'b0;
  logic                 cfg_we_i     = 1'b0;
  logic                 cfg_idx_i    = 1'b0;
  logic [AddrW-1:0]     cfg_data_i   = '0;
  logic                 in_valid_i   = 1'b0;
  logic                 in_ready_o;
  logic [1:0]           req_type_i   = '0;
  logic [AddrW-1:0]     address_i    = '0;
  logic [SizeInW-1:0]   size_bytes_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i  = 1'b0;
  logic [AddrW-1:0]     result_address_o;
  logic [1:0]           status_o;
  logic [SizeW-1:0]     granted_size_o;
  logic                 same_place_o;

  // local copy of the fragment table and the two registers
  logic                 frag_valid [TableEntries];
  logic [AddrW-1:0]     frag_start [TableEntries];
  logic [SizeW-1:0]     frag_size  [TableEntries];
  logic [AddrW-1:0]     base_reg  = '0;
  logic [AddrW-1:0]     limit_reg = '1;

  // results still owed by the block, oldest first
  alloc_result_t        pending_results [$];

  // run bookkeeping
  int                   errors      = 0;
  int                   n_requests  = 0;
  int                   n_moved     = 0;
  int                   n_in_place  = 0;
  int                   n_status [4];
  bit                   no_idle     = 1'b0;  // both sides stop idling while set
  int                   hold_req    = 0;     // receiver picks this up as its next gap

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  first_fit_fragment_allocator_core #(
    .TABLE_ENTRIES(TableEntries)
  ) i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .req_type_i      (req_type_i),
    .address_i       (address_i),
    .size_bytes_i    (size_bytes_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .result_address_o(result_address_o),
    .status_o        (status_o),
    .granted_size_o  (granted_size_o),
    .same_place_o    (same_place_o)
  );

  // idle cycles before the next transfer on either side
  function automatic int draw_gap();
    if (no_idle) return 0;
    return $urandom_range(0, MaxGap);
  endfunction

  // first-fit search: lowest from + 4k whose span is clear and ends inside the region,
  // jumping past the lowest-numbered overlapping fragment each time
  function automatic bit find_room(input logic [63:0] from, input logic [SizeW-1:0] len,
                                   output logic [AddrW-1:0] where);
    logic [63:0] cand;
    logic [63:0] frag_end;
    logic [63:0] jump;
    int          hit;
    cand  = from;
    where = '0;
    // every jump clears one fragment for good, so one pass more than entries is enough
    for (int pass = 0; pass <= TableEntries; pass++) begin
      if (cand + len > {32'd0, limit_reg}) return 1'b0;
      hit = -1;
      for (int i = TableEntries - 1; i >= 0; i--) begin
        if (frag_valid[i] && {32'd0, frag_start[i]} < cand + len &&
            {32'd0, frag_start[i]} + frag_size[i] > cand) begin
          hit = i;
        end
      end
      if (hit < 0) begin
        where = cand[AddrW-1:0];
        return 1'b1;
      end
      frag_end = {32'd0, frag_start[hit]} + frag_size[hit];
      jump     = (frag_end - cand + 64'd3) & ~64'd3;
      cand     = cand + jump;
    end
    return 1'b0;
  endfunction

  // applies one request to the table copy and returns the result it must produce
  function automatic alloc_result_t serve_request(input logic [1:0] kind,
                                                  input logic [AddrW-1:0] addr,
                                                  input logic [SizeInW-1:0] size_in);
    alloc_result_t    res;
    logic [SizeW-1:0] len;
    logic [AddrW-1:0] where;
    int               slot;
    res        = '0;
    res.status = STAT_OK;
    // sizes go up to the next multiple of four
    len        = ({1'b0, size_in} + 17'd3) & ~17'd3;
    slot       = -1;
    case (kind)
      REQ_ALLOC: begin
        for (int i = TableEntries - 1; i >= 0; i--) begin
          if (!frag_valid[i]) slot = i;
        end
        // a full table is reported before any search
        if (slot < 0) begin
          res.status = STAT_FULL;
        end else if (!find_room({32'd0, base_reg & ~32'd3}, len, where)) begin
          res.status = STAT_NO_SPACE;
        end else begin
          frag_valid[slot] = 1'b1;
          frag_start[slot] = where;
          frag_size[slot]  = len;
          res.address      = where;
          res.size         = len;
        end
      end
      REQ_REALLOC: begin
        // lowest-numbered entry with that start
        for (int i = TableEntries - 1; i >= 0; i--) begin
          if (frag_valid[i] && frag_start[i] == addr) slot = i;
        end
        if (slot < 0) begin
          res.status = STAT_NOT_FOUND;
        end else if (frag_size[slot] >= len) begin
          frag_size[slot] = len;
          res.address     = addr;
          res.size        = len;
          res.same_place  = 1'b1;
          n_in_place++;
        end else if (!find_room({32'd0, frag_start[slot]} + frag_size[slot], len, where)) begin
          res.status = STAT_NO_SPACE;
        end else begin
          // the old fragment stays taken during the search, then its entry is reused
          frag_start[slot] = where;
          frag_size[slot]  = len;
          res.address      = where;
          res.size         = len;
          res.same_place   = (where == addr);
          if (where == addr) n_in_place++;
          else n_moved++;
        end
      end
      REQ_FREE: begin
        // every entry with that start goes
        for (int i = 0; i < TableEntries; i++) begin
          if (frag_valid[i] && frag_start[i] == addr) begin
            frag_valid[i] = 1'b0;
            slot          = i;
          end
        end
        if (slot < 0) res.status = STAT_NOT_FOUND;
        else res.address = addr;
      end
      default: begin
        res.status = STAT_NOT_FOUND;
      end
    endcase
    return res;
  endfunction

  // start of a random live fragment; a random address when the table is empty
  function automatic bit pick_live(output logic [AddrW-1:0] addr);
    int live [$];
    addr = $urandom;
    for (int i = 0; i < TableEntries; i++) begin
      if (frag_valid[i]) live.insert(live.size(), i);
    end
    if (live.size() == 0) return 1'b0;
    addr = frag_start[live[$urandom_range(0, live.size() - 1)]];
    return 1'b1;
  endfunction

  // one request transfer; valid stays up when the next request follows at once
  task automatic send_request(input logic [1:0] kind, input logic [AddrW-1:0] addr,
                              input logic [SizeInW-1:0] size_in);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    req_type_i   <= kind;
    address_i    <= addr;
    size_bytes_i <= size_in;
    do @(posedge clk_i); while (!in_ready_o);
    pending_results.insert(pending_results.size(), serve_request(kind, addr, size_in));
    n_requests++;
  endtask

  // drop valid, let every owed result come back, then let the block settle
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // register write, only ever issued while the block is idle
  task automatic write_reg(input logic idx, input logic [AddrW-1:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CfgBaseAddr) base_reg = value;
    else limit_reg = value;
    @(posedge clk_i);
  endtask

  // frees whatever the table still holds
  task automatic free_all();
    logic [AddrW-1:0] addr;
    while (pick_live(addr)) send_request(REQ_FREE, addr, 16'($urandom));
  endtask

  // empty the table, set a region, then a random mix of requests inside it
  task automatic run_region(input logic [AddrW-1:0] base, input logic [AddrW-1:0] limit,
                            input int items, input int max_small, input bit burst);
    logic [AddrW-1:0]   addr;
    logic [SizeInW-1:0] size_in;
    int                 roll;
    wait_idle();
    free_all();
    wait_idle();
    write_reg(CfgBaseAddr, base);
    write_reg(CfgRegionEnd, limit);
    no_idle = burst;
    for (int n = 0; n < items; n++) begin
      // now and then a stretch where neither side idles
      if (!burst && n % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
      void'(pick_live(addr));
      if ($urandom_range(0, 9) == 0) addr = $urandom;
      case ($urandom_range(0, 9))
        0: size_in = '0;
        1: size_in = 16'($urandom);
        default: size_in = 16'($urandom_range(0, max_small));
      endcase
      roll = $urandom_range(0, 99);
      if (roll < 45) send_request(REQ_ALLOC, $urandom, size_in);
      else if (roll < 70) send_request(REQ_REALLOC, addr, size_in);
      else if (roll < 94) send_request(REQ_FREE, addr, 16'($urandom));
      else send_request(ReqUnknown, $urandom, 16'($urandom));
    end
    no_idle = 1'b0;
  endtask

  // hand-picked sequence in a 256-byte region: zero sizes, duplicate starts,
  // realloc in place and moving, exact fit, no space, unknown address and request
  task automatic test_directed_region();
    write_reg(CfgBaseAddr, 32'h0000_0103);  // low bits of the base are dropped
    write_reg(CfgRegionEnd, 32'h0000_0200);
    send_request(REQ_ALLOC,   32'h0,         16'd0);
    send_request(REQ_ALLOC,   32'h0,         16'd0);
    send_request(REQ_ALLOC,   32'h0,         16'd5);
    send_request(REQ_REALLOC, 32'h100,       16'd4);
    send_request(REQ_FREE,    32'h100,       16'd0);
    send_request(REQ_REALLOC, 32'h108,       16'd0);
    send_request(REQ_REALLOC, 32'h108,       16'd16);
    send_request(REQ_ALLOC,   32'h0,         16'h00E8);
    send_request(REQ_REALLOC, 32'h108,       16'd20);
    send_request(REQ_FREE,    32'hFFFF_FFFF, 16'hFFFF);
    send_request(ReqUnknown,  32'hFFFF_FFFF, 16'hFFFF);
  endtask

  // fill every entry with zero-size fragments at one start, then hit the full table
  task automatic test_table_full();
    wait_idle();
    free_all();
    wait_idle();
    write_reg(CfgBaseAddr, 32'h0);
    write_reg(CfgRegionEnd, 32'hFFFF_FFFF);
    for (int n = 0; n < TableEntries; n++) send_request(REQ_ALLOC, 32'h0, 16'd0);
    send_request(REQ_ALLOC,   32'h0, 16'd4);
    // grows into its own entry although no entry is free
    send_request(REQ_REALLOC, 32'h0, 16'hFFFF);
    send_request(REQ_REALLOC, 32'h0, 16'd8);
    send_request(REQ_FREE,    32'h0, 16'd0);
  endtask

  // random traffic over wide, tight, high, boundary and degenerate regions
  task automatic test_random_traffic();
    run_region(32'h0000_0000, 32'hFFFF_FFFF, 250, 4096, 1'b0);
    run_region(32'h0000_1000, 32'h0000_1400, 320, 160,  1'b0);
    run_region(32'hFFFF_0002, 32'hFFFF_FFFF, 230, 8192, 1'b0);
    run_region(32'h7FFF_FFF0, 32'h8000_0100, 200, 48,   1'b0);
    run_region(32'h0000_0000, 32'h0000_0000, 80,  3,    1'b0);
    run_region(32'hFFFF_FFFF, 32'hFFFF_FFFF, 60,  3,    1'b0);
  endtask

  // result side held off for a long stretch while requests keep coming,
  // then the request side waits until everything is back
  task automatic test_output_backpressure();
    logic [AddrW-1:0] addr;
    wait_idle();
    hold_req = LongHold;
    no_idle  = 1'b1;
    for (int n = 0; n < 16; n++) begin
      if (n % 3 == 2 && pick_live(addr)) send_request(REQ_FREE, addr, 16'd0);
      else send_request(REQ_ALLOC, 32'h0, 16'($urandom_range(0, 64)));
    end
    no_idle = 1'b0;
    wait_idle();
  endtask

  // back-to-back transfers on both sides for a whole phase
  task automatic test_back_to_back();
    run_region(32'h0000_2000, 32'h0000_2800, 200, 200, 1'b1);
  endtask

  // stimulus: reset once, then each test in turn
  initial begin : stimulus
    for (int i = 0; i < TableEntries; i++) frag_valid[i] = 1'b0;
    for (int i = 0; i < 4; i++) n_status[i] = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_region();
    test_table_full();
    test_random_traffic();
    test_output_backpressure();
    test_back_to_back();
    wait_idle();
    $display("Ran %0d requests: %0d ok, %0d out of space, %0d table full, %0d unknown address",
             n_requests, n_status[STAT_OK], n_status[STAT_NO_SPACE], n_status[STAT_FULL],
             n_status[STAT_NOT_FOUND]);
    $display("Reallocations: %0d moved, %0d kept their address; nine region settings",
             n_moved, n_in_place);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // result side: random ready gaps, each transfer checked against the oldest owed result
  initial begin : result_checker
    alloc_result_t want;
    int            gap;
    @(posedge rst_ni);
    forever begin
      gap      = (hold_req > 0) ? hold_req : draw_gap();
      hold_req = 0;
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding: address %h status %0d",
               result_address_o, status_o);
        errors++;
      end else begin
        want = pending_results.pop_front();
        n_status[want.status]++;
        if (result_address_o !== want.address) begin
          $error("result_address: expected %h, got %h", want.address, result_address_o);
          errors++;
        end
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          errors++;
        end
        if (granted_size_o !== want.size) begin
          $error("granted_size: expected %0d, got %0d", want.size, granted_size_o);
          errors++;
        end
        if (same_place_o !== want.same_place) begin
          $error("same_place: expected %0d, got %0d", want.same_place, same_place_o);
          errors++;
        end
      end
    end
  end

  // hang guard
  initial begin : run_limit
    #(RunLimitNs);
    $error("run limit reached, %0d results still owed", pending_results.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ----- first_fit_fragment_allocator_core.f -----
+incdir+rtl/core
rtl/core/ffa_pkg.sv
rtl/core/ffa_ctrl.sv
rtl/core/ffa_datapath.sv
rtl/core/first_fit_fragment_allocator_core.sv
verif/tb.sv
